/* rtl/utf8cc_pkg.sv */
// shared types, constants and lead-byte helpers for the utf-8 counter/decoder
`default_nettype none

package utf8cc_pkg;

  localparam int MAX_LEN_DEF = 65536;
  localparam int COUNT_W     = 17;
  localparam int IDX_W       = 16;
  localparam int CODE_W      = 16;
  localparam int BYTE_W      = 8;
  localparam int OUT_TDATA_W = 40;  // 17 + 16 bits rounded up to whole bytes

  localparam logic [COUNT_W-1:0] COUNT_LIMIT = 17'h1FFFF;
  localparam logic [CODE_W-1:0]  REPLACEMENT = 16'hFFFD;

  // input beat held in the first stage
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              byte_present;
    logic              last_byte;
  } beat_t;

  typedef struct packed {
    logic [COUNT_W-1:0] char_total;
    logic [CODE_W-1:0]  code_unit;
    logic               status;
  } result_t;

  typedef enum logic [1:0] {
    LEAD_ONE   = 2'd0,
    LEAD_TWO   = 2'd1,
    LEAD_THREE = 2'd2,
    LEAD_FOUR  = 2'd3
  } lead_t;

  localparam logic STATUS_FOUND = 1'b0;
  localparam logic STATUS_OOB   = 1'b1;

  // number of bytes to skip after a lead; invalid leads count as one-byte
  function automatic lead_t lead_kind(input logic [BYTE_W-1:0] b);
    lead_t k;
    priority if (b[7] == 1'b0)          k = LEAD_ONE;
    else if (b[7:5] == 3'b110)          k = LEAD_TWO;
    else if (b[7:4] == 4'b1110)         k = LEAD_THREE;
    else if (b[7:3] == 5'b11110)        k = LEAD_FOUR;
    else                                k = LEAD_ONE;
    return k;
  endfunction

endpackage

`default_nettype wire

/* rtl/utf8cc_in_reg.sv */
// input stage register with pass-through ready
`default_nettype none

module utf8cc_in_reg (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire utf8cc_pkg::beat_t in_beat,
  input  wire logic            out_free,
  output utf8cc_pkg::beat_t    beat,
  output logic                 fire
);
  import utf8cc_pkg::*;

  logic held;

  // a last beat needs room in the result register, other beats go straight through
  assign fire     = held && (!beat.last_byte || out_free);
  assign in_ready = !held || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      beat <= in_beat;
    end
  end

endmodule

`default_nettype wire

/* rtl/utf8cc_core.sv */
// stream state, character counter and code-unit decoder
`default_nettype none

module utf8cc_core #(
  parameter int MAX_LEN = utf8cc_pkg::MAX_LEN_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_wr_en,
  input  wire logic [utf8cc_pkg::IDX_W-1:0]   cfg_wr_data,
  input  wire utf8cc_pkg::beat_t              beat,
  input  wire logic                           fire,
  output utf8cc_pkg::result_t                 result
);
  import utf8cc_pkg::*;

  localparam logic [COUNT_W-1:0] COUNT_CAP =
    (longint'(MAX_LEN) < longint'(COUNT_LIMIT)) ? COUNT_W'(MAX_LEN) : COUNT_LIMIT;

  logic [IDX_W-1:0]   target_index;
  logic [1:0]         skip_left,    skip_left_next;
  logic [COUNT_W-1:0] char_counter, char_counter_next;
  logic [1:0]         decode_need,  decode_need_next;
  logic [CODE_W-1:0]  decode_acc,   decode_acc_next;
  logic               found_flag,   found_flag_next;
  lead_t              kind;
  logic [BYTE_W-1:0]  b;

  assign b    = beat.data_byte;
  assign kind = lead_kind(b);

  always_ff @(posedge clk) begin
    if (rst) begin
      target_index <= '0;
    end else if (cfg_wr_en) begin
      target_index <= cfg_wr_data;
    end
  end

  always_comb begin
    skip_left_next    = skip_left;
    char_counter_next = char_counter;
    decode_need_next  = decode_need;
    decode_acc_next   = decode_acc;
    found_flag_next   = found_flag;
    if (beat.byte_present) begin
      if (skip_left != 2'd0) begin
        // continuation byte, prefix not checked
        skip_left_next = skip_left - 2'd1;
        if (decode_need != 2'd0) begin
          decode_acc_next  = {decode_acc[CODE_W-7:0], b[5:0]};
          decode_need_next = decode_need - 2'd1;
        end
      end else begin
        if (!found_flag && char_counter == {1'b0, target_index}) begin
          found_flag_next = 1'b1;
          unique case (kind)
            LEAD_ONE: begin
              // ascii or invalid lead
              decode_acc_next  = (b[7] == 1'b0) ? {8'h00, b} : REPLACEMENT;
              decode_need_next = 2'd0;
            end
            LEAD_TWO: begin
              decode_acc_next  = {11'd0, b[4:0]};
              decode_need_next = 2'd1;
            end
            LEAD_THREE: begin
              decode_acc_next  = {12'd0, b[3:0]};
              decode_need_next = 2'd2;
            end
            LEAD_FOUR: begin
              decode_acc_next  = REPLACEMENT;
              decode_need_next = 2'd0;
            end
            default: begin
              decode_acc_next  = REPLACEMENT;
              decode_need_next = 2'd0;
            end
          endcase
        end
        skip_left_next = kind;
        if (char_counter < COUNT_CAP) begin
          char_counter_next = char_counter + 1'b1;
        end
      end
    end
  end

  always_comb begin
    result.char_total = char_counter_next;
    result.code_unit  = (found_flag_next && decode_need_next == 2'd0) ? decode_acc_next : '0;
    result.status     = found_flag_next ? STATUS_FOUND : STATUS_OOB;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      skip_left    <= '0;
      char_counter <= '0;
      decode_need  <= '0;
      decode_acc   <= '0;
      found_flag   <= 1'b0;
    end else if (fire) begin
      if (beat.last_byte) begin
        // end of string clears all stream state for the next one
        skip_left    <= '0;
        char_counter <= '0;
        decode_need  <= '0;
        decode_acc   <= '0;
        found_flag   <= 1'b0;
      end else begin
        skip_left    <= skip_left_next;
        char_counter <= char_counter_next;
        decode_need  <= decode_need_next;
        decode_acc   <= decode_acc_next;
        found_flag   <= found_flag_next;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/utf8cc_out_reg.sv */
// result register driving the master-side beat
`default_nettype none

module utf8cc_out_reg (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                load,
  input  wire utf8cc_pkg::result_t                 result,
  output logic                                     out_free,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  output logic [utf8cc_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
  output logic                                     m_axis_tuser
);
  import utf8cc_pkg::*;

  result_t held;

  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && load) begin
      held <= result;
    end
  end

  assign m_axis_tdata = {{(OUT_TDATA_W - COUNT_W - CODE_W){1'b0}},
                         held.code_unit, held.char_total};
  assign m_axis_tuser = held.status;

endmodule

`default_nettype wire

/* rtl/utf8_char_count_and_index_decode.sv */
// path: an accepted beat is held in the input register, and its result is then held in the
//   result register that drives the master side
// throughput: one byte per cycle; only a stalled result with a last beat waiting stalls input
// reset: synchronous active-high rst clears stream state, target_index and both valid flags
// one result per string, on the beat marked tlast
`default_nettype none

module utf8_char_count_and_index_decode #(
  parameter int MAX_LEN = utf8cc_pkg::MAX_LEN_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_wr_en,
  input  wire logic [utf8cc_pkg::IDX_W-1:0]      cfg_wr_data,    // target_index
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [utf8cc_pkg::BYTE_W-1:0]     s_axis_tdata,   // [7:0] data_byte
  input  wire logic                              s_axis_tuser,   // [0] byte_present
  input  wire logic                              s_axis_tlast,   // last_byte
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [utf8cc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,   // [16:0] char_total, [32:17] code_unit, [39:33] zero
  output logic                                   m_axis_tuser    // [0] status
);
  import utf8cc_pkg::*;

  beat_t   in_beat;
  beat_t   beat;
  result_t result;
  logic    fire;
  logic    out_free;

  assign in_beat = '{data_byte: s_axis_tdata, byte_present: s_axis_tuser,
                     last_byte: s_axis_tlast};

  utf8cc_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_beat  (in_beat),
    .out_free (out_free),
    .beat     (beat),
    .fire     (fire)
  );

  utf8cc_core #(
    .MAX_LEN (MAX_LEN)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .beat        (beat),
    .fire        (fire),
    .result      (result)
  );

  utf8cc_out_reg u_out_reg (
    .clk           (clk),
    .rst           (rst),
    .load          (fire && beat.last_byte),
    .result        (result),
    .out_free      (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

`default_nettype wire

/* rtl/utf8cc_checker.sv */
// port-level checker for the utf-8 counter/decoder, bound to the top level
`default_nettype none

module utf8cc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata,
  input wire logic        m_axis_tuser
);

  // nothing comes out in the cycle after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result beat right after reset");

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result beat changed");

  // out of bounds gives a zero code unit
  a_oob_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[32:17] == 16'd0)
    else $error("code unit nonzero on out-of-bounds result");

  // an empty string can never find its target
  a_empty_oob: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[16:0] == 17'd0 |-> m_axis_tuser)
    else $error("target found in a string with no characters");

  // padding bits stay zero
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[39:33] == 7'd0)
    else $error("padding bits set in result beat");

endmodule

bind utf8_char_count_and_index_decode utf8cc_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
